FILE: rtl/core/gbfr_pkg.sv
// shared types and constants for the binary gnss frame receiver
package gbfr_pkg;

    localparam int MAX_FRAME_PAYLOAD = 1024;
    localparam int LIMIT_W = 11;
    localparam int POS_WORDS = 7;
    localparam int POS_BYTES = 28;
    localparam int POS_IDX_W = 5;

    localparam logic [7:0] SYNC_FIRST = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] CLASS_NAV = 8'h01;
    localparam logic [7:0] ID_POSLLH = 8'h02;
    localparam logic [LIMIT_W-1:0] MAX_PAYLOAD_RST = 11'd512;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_CK,
        ST_TOO_LONG
    } status_t;

    typedef struct packed {
        logic                   valid;
        logic [7:0]             frame_class;
        logic [7:0]             frame_id;
        logic [15:0]            payload_length;
        status_t                status;
        logic                   pos_valid;
        logic [POS_WORDS-1:0][31:0] pos_words;
    } result_t;

endpackage

FILE: rtl/core/gnss_binary_frame_receiver_top.sv
// top level of the binary gnss frame receiver
// path: a byte accepted into the input register is parsed from there, and any result
// it ends is loaded into the output register, where it waits until it is taken
// throughput: one byte per cycle; a result waiting in the output register
// only holds back a byte that would itself end a frame
// reset: asynchronous active low; parser hunts the first sync byte,
// max_payload returns to 512, input and output registers empty
module gnss_binary_frame_receiver_top
    import gbfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          frame_class,
    output logic [7:0]          frame_id,
    output logic [15:0]         payload_length,
    output logic [1:0]          frame_status,
    output logic                position_valid,
    output logic [31:0]         time_of_week,
    output logic signed [31:0]  longitude,
    output logic signed [31:0]  latitude,
    output logic signed [31:0]  height_ellipsoid,
    output logic signed [31:0]  height_sea_level,
    output logic [31:0]         horiz_accuracy,
    output logic [31:0]         vert_accuracy
);

    logic [LIMIT_W-1:0] max_payload_reg;
    logic               in_vld_reg, in_vld_next;
    logic [7:0]         in_byte_reg;
    logic               out_vld_reg, out_vld_next;
    result_t            out_res_reg;
    result_t            res;
    logic               accept_in;
    logic               step;

    gbfr_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .max_payload (max_payload_reg),
        .res         (res)
    );

    always_comb
    begin
        step = in_vld_reg && (!res.valid || !out_vld_reg || !out_stall);
        in_stall = in_vld_reg && !step;
        accept_in = in_valid && !in_stall;
        if (accept_in)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
        if (step && res.valid)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_payload_reg <= cfg_wr_data;
            end
            in_vld_reg <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && res.valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_vld_reg;
    assign frame_class = out_res_reg.frame_class;
    assign frame_id = out_res_reg.frame_id;
    assign payload_length = out_res_reg.payload_length;
    assign frame_status = out_res_reg.status;
    assign position_valid = out_res_reg.pos_valid;
    assign time_of_week = out_res_reg.pos_words[0];
    assign longitude = signed'(out_res_reg.pos_words[1]);
    assign latitude = signed'(out_res_reg.pos_words[2]);
    assign height_ellipsoid = signed'(out_res_reg.pos_words[3]);
    assign height_sea_level = signed'(out_res_reg.pos_words[4]);
    assign horiz_accuracy = out_res_reg.pos_words[5];
    assign vert_accuracy = out_res_reg.pos_words[6];

    // a new result never lands on one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.valid) |-> !(out_vld_reg && out_stall))
        else $error("result overwrote a pending item");

    // position words only come with a good checksum on a position frame
    a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && position_valid) |->
            (frame_status == ST_OK && frame_class == CLASS_NAV
             && frame_id == ID_POSLLH && payload_length == 16'(POS_BYTES)))
        else $error("position valid on a wrong frame");

    // input side only stalls with a byte held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg)
        else $error("stall without a held byte");

    // a too-long status is never reported with position data
    a_long_nopos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && frame_status == ST_TOO_LONG) |->
            (!position_valid && payload_length != 16'd0))
        else $error("bad length result");

endmodule

FILE: rtl/core/gbfr_parse.sv
// frame parser: sync hunt, header, payload capture and fletcher-8 check
module gbfr_parse
    import gbfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    input  logic [LIMIT_W-1:0] max_payload,
    output result_t            res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  ck_a_reg, ck_a_next;
    logic [7:0]  pos_byte_reg [POS_BYTES];

    logic [7:0]         add_a;
    logic [7:0]         add_b;
    logic [15:0]        new_length;
    logic [LIMIT_W-1:0] limit;
    logic               too_long;
    logic [15:0]        count_inc;
    logic               is_pos;
    logic               pos_wr;

    always_comb
    begin
        add_a = sum_a_reg + rx_byte;
        add_b = sum_b_reg + add_a;
        new_length = {rx_byte, length_reg[7:0]};
        if (max_payload > LIMIT_W'(MAX_FRAME_PAYLOAD))
        begin
            limit = LIMIT_W'(MAX_FRAME_PAYLOAD);
        end
        else
        begin
            limit = max_payload;
        end
        too_long = new_length > {5'd0, limit};
        count_inc = count_reg + 16'd1;
        is_pos = (class_reg == CLASS_NAV) && (id_reg == ID_POSLLH);
        pos_wr = (phase_reg == PH_PAYLOAD) && is_pos && (count_reg < 16'(POS_BYTES));
    end

    // next phase
    always_comb
    begin
        case (phase_reg)
            PH_SYNC1:   phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            PH_SYNC2:
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    phase_next = PH_CLASS;
                end
                else if (rx_byte == SYNC_FIRST)
                begin
                    phase_next = PH_SYNC2;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_CLASS:   phase_next = PH_ID;
            PH_ID:      phase_next = PH_LEN_LO;
            PH_LEN_LO:  phase_next = PH_LEN_HI;
            PH_LEN_HI:
            begin
                if (too_long)
                begin
                    phase_next = PH_SYNC1;
                end
                else if (new_length == 16'd0)
                begin
                    phase_next = PH_CK_A;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: phase_next = (count_inc >= length_reg) ? PH_CK_A : PH_PAYLOAD;
            PH_CK_A:    phase_next = PH_CK_B;
            default:    phase_next = PH_SYNC1;
        endcase
    end

    // datapath and result
    always_comb
    begin
        class_next = class_reg;
        id_next = id_reg;
        length_next = length_reg;
        count_next = count_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        ck_a_next = ck_a_reg;
        res = '0;
        res.frame_class = class_reg;
        res.frame_id = id_reg;
        case (phase_reg)
            PH_SYNC2:
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    sum_a_next = '0;
                    sum_b_next = '0;
                end
            end
            PH_CLASS:
            begin
                class_next = rx_byte;
                sum_a_next = add_a;
                sum_b_next = add_b;
            end
            PH_ID:
            begin
                id_next = rx_byte;
                sum_a_next = add_a;
                sum_b_next = add_b;
            end
            PH_LEN_LO:
            begin
                length_next = {8'd0, rx_byte};
                sum_a_next = add_a;
                sum_b_next = add_b;
            end
            PH_LEN_HI:
            begin
                length_next = new_length;
                sum_a_next = add_a;
                sum_b_next = add_b;
                count_next = '0;
                res.valid = too_long;
                res.payload_length = new_length;
                res.status = ST_TOO_LONG;
            end
            PH_PAYLOAD:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                count_next = count_inc;
            end
            PH_CK_A:
            begin
                ck_a_next = rx_byte;
            end
            PH_CK_B:
            begin
                res.valid = 1'b1;
                res.payload_length = length_reg;
                if ((ck_a_reg == sum_a_reg) && (rx_byte == sum_b_reg))
                begin
                    res.status = ST_OK;
                end
                else
                begin
                    res.status = ST_BAD_CK;
                end
                if ((res.status == ST_OK) && is_pos && (length_reg == 16'(POS_BYTES)))
                begin
                    res.pos_valid = 1'b1;
                    for (int w = 0; w < POS_WORDS; w++)
                    begin
                        res.pos_words[w] = {pos_byte_reg[4*w+3], pos_byte_reg[4*w+2],
                                            pos_byte_reg[4*w+1], pos_byte_reg[4*w]};
                    end
                end
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            class_reg <= '0;
            id_reg <= '0;
            length_reg <= '0;
            count_reg <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            ck_a_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            id_reg <= id_next;
            length_reg <= length_next;
            count_reg <= count_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            ck_a_reg <= ck_a_next;
        end
    end

    // position capture bytes
    always_ff @(posedge clk)
    begin
        if (step && pos_wr)
        begin
            pos_byte_reg[count_reg[POS_IDX_W-1:0]] <= rx_byte;
        end
    end

endmodule

FILE: bench/tb.sv
// testbench for the binary gnss frame receiver: frame predictor, scoreboard and byte drivers
module tb;
    import gbfr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 90;
    localparam int RANDOM_BYTES = 400;
    localparam int RANDOM_FRAMES = 15;

    typedef enum int {
        CK_CLEAN,
        CK_BAD_A,
        CK_BAD_B
    } ck_fault_t;

    typedef struct packed {
        logic [7:0]                 cls;
        logic [7:0]                 id;
        logic [15:0]                len;
        status_t                    status;
        logic                       pos_valid;
        logic [POS_WORDS-1:0][31:0] pos;
    } frame_result_t;

    class frame_tracker;
        phase_t          phase;
        logic [7:0]      cls;
        logic [7:0]      id;
        logic [15:0]     len;
        logic [15:0]     count;
        logic [7:0]      sum_a;
        logic [7:0]      sum_b;
        logic [7:0]      ck_a;
        logic [31:0]     words [POS_WORDS];
        logic [10:0]     max_payload;
        frame_result_t   awaited_frames[$];
        string           word_names [POS_WORDS];
        int              errors;
        int              frames_checked;
        int              fixes;
        int              bad_sums;
        int              too_long;

        function new();
            phase = PH_SYNC1;
            cls = '0;
            id = '0;
            len = '0;
            count = '0;
            sum_a = '0;
            sum_b = '0;
            ck_a = '0;
            foreach (words[i])
                words[i] = '0;
            max_payload = MAX_PAYLOAD_RST;
            word_names = '{"time_of_week", "longitude", "latitude", "height_ellipsoid",
                           "height_sea_level", "horiz_accuracy", "vert_accuracy"};
            errors = 0;
            frames_checked = 0;
            fixes = 0;
            bad_sums = 0;
            too_long = 0;
        endfunction

        function int payload_limit();
            return (max_payload > MAX_FRAME_PAYLOAD) ? MAX_FRAME_PAYLOAD : int'(max_payload);
        endfunction

        function void add_sums(logic [7:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function frame_result_t header_result(status_t status);
            frame_result_t r;
            r = '0;
            r.cls = cls;
            r.id = id;
            r.len = len;
            r.status = status;
            return r;
        endfunction

        // advance the parser by one accepted item
        function void take_byte(logic [7:0] b);
            frame_result_t r;
            status_t status;
            case (phase)
                PH_SYNC1:
                begin
                    if (b == SYNC_FIRST)
                        phase = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    if (b == SYNC_SECOND)
                    begin
                        phase = PH_CLASS;
                        sum_a = '0;
                        sum_b = '0;
                    end
                    else if (b != SYNC_FIRST)
                        phase = PH_SYNC1;
                end
                PH_CLASS:
                begin
                    cls = b;
                    add_sums(b);
                    phase = PH_ID;
                end
                PH_ID:
                begin
                    id = b;
                    add_sums(b);
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len = {8'h00, b};
                    add_sums(b);
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len = {b, len[7:0]};
                    add_sums(b);
                    count = '0;
                    if (int'(len) > payload_limit())
                    begin
                        awaited_frames.push_back(header_result(ST_TOO_LONG));
                        phase = PH_SYNC1;
                    end
                    else
                        phase = (len == 0) ? PH_CK_A : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    add_sums(b);
                    if (cls == CLASS_NAV && id == ID_POSLLH && count < POS_BYTES)
                        words[count >> 2][(count & 3) * 8 +: 8] = b;
                    count = count + 16'd1;
                    if (count >= len)
                        phase = PH_CK_A;
                end
                PH_CK_A:
                begin
                    ck_a = b;
                    phase = PH_CK_B;
                end
                PH_CK_B:
                begin
                    status = (ck_a == sum_a && b == sum_b) ? ST_OK : ST_BAD_CK;
                    r = header_result(status);
                    if (status == ST_OK && cls == CLASS_NAV && id == ID_POSLLH
                        && len == POS_BYTES)
                    begin
                        r.pos_valid = 1'b1;
                        foreach (words[j])
                            r.pos[j] = words[j];
                    end
                    awaited_frames.push_back(r);
                    phase = PH_SYNC1;
                end
                default:
                    phase = PH_SYNC1;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s expected %0h got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_frame(frame_result_t got);
            frame_result_t want;
            if (awaited_frames.size() == 0)
            begin
                $error("frame class %0h id %0h arrived with none expected", got.cls, got.id);
                errors++;
                return;
            end
            want = awaited_frames.pop_front();
            frames_checked++;
            if (want.pos_valid)
                fixes++;
            if (want.status == ST_BAD_CK)
                bad_sums++;
            if (want.status == ST_TOO_LONG)
                too_long++;
            compare_field("frame_class", want.cls, got.cls);
            compare_field("frame_id", want.id, got.id);
            compare_field("payload_length", want.len, got.len);
            compare_field("frame_status", want.status, got.status);
            compare_field("position_valid", want.pos_valid, got.pos_valid);
            for (int j = 0; j < POS_WORDS; j++)
                compare_field(word_names[j], want.pos[j], got.pos[j]);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          rx_byte = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [7:0]          frame_class;
    logic [7:0]          frame_id;
    logic [15:0]         payload_length;
    logic [1:0]          frame_status;
    logic                position_valid;
    logic [31:0]         time_of_week;
    logic signed [31:0]  longitude;
    logic signed [31:0]  latitude;
    logic signed [31:0]  height_ellipsoid;
    logic signed [31:0]  height_sea_level;
    logic [31:0]         horiz_accuracy;
    logic [31:0]         vert_accuracy;

    frame_tracker tracker = new();
    logic [7:0]   payload_buf [MAX_FRAME_PAYLOAD];
    logic         in_steady = 1'b0;
    logic         out_steady = 1'b0;
    int           bytes_sent = 0;
    int           cfg_writes = 0;
    int           cycles = 0;

    gnss_binary_frame_receiver_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .frame_class      (frame_class),
        .frame_id         (frame_id),
        .payload_length   (payload_length),
        .frame_status     (frame_status),
        .position_valid   (position_valid),
        .time_of_week     (time_of_week),
        .longitude        (longitude),
        .latitude         (latitude),
        .height_ellipsoid (height_ellipsoid),
        .height_sea_level (height_sea_level),
        .horiz_accuracy   (horiz_accuracy),
        .vert_accuracy    (vert_accuracy)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    // sync, header, payload from payload_buf, check bytes; header only when over the limit
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input ck_fault_t fault);
        logic [7:0] hdr [4];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        hdr = '{cls, id, len[7:0], len[15:8]};
        ck_a = '0;
        ck_b = '0;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        for (int i = 0; i < 4; i++)
        begin
            send_byte(hdr[i]);
            ck_a = ck_a + hdr[i];
            ck_b = ck_b + ck_a;
        end
        if (int'(len) > tracker.payload_limit())
            return;
        for (int i = 0; i < int'(len); i++)
        begin
            send_byte(payload_buf[i]);
            ck_a = ck_a + payload_buf[i];
            ck_b = ck_b + ck_a;
        end
        if (fault == CK_BAD_A)
            ck_a = ck_a ^ 8'($urandom_range(1, 255));
        if (fault == CK_BAD_B)
            ck_b = ck_b ^ 8'($urandom_range(1, 255));
        send_byte(ck_a);
        send_byte(ck_b);
    endtask

    task automatic fill_payload(input int len);
        for (int i = 0; i < len && i < MAX_FRAME_PAYLOAD; i++)
            payload_buf[i] = 8'($urandom);
    endtask

    task automatic random_frame();
        logic [7:0] cls;
        logic [7:0] id;
        int         len;
        int         lim;
        int         pick;
        int         roll;
        ck_fault_t  fault;
        lim = tracker.payload_limit();
        if ($urandom_range(0, 5) == 0)
            in_steady = !in_steady;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            cls = CLASS_NAV;
            id = ID_POSLLH;
            len = ($urandom_range(0, 2) != 0) ? POS_BYTES : $urandom_range(0, 40);
        end
        else
        begin
            cls = (pick == 4) ? CLASS_NAV : 8'($urandom);
            id = 8'($urandom);
            len = $urandom_range(0, 16);
        end
        if (len > lim)
            len = lim;
        if (pick == 9)
            len = $urandom_range(lim + 1, 65535);
        roll = $urandom_range(0, 7);
        fault = (roll == 0) ? CK_BAD_A : (roll == 1) ? CK_BAD_B : CK_CLEAN;
        fill_payload(len);
        send_frame(cls, id, 16'(len), fault);
    endtask

    // only between frames, once every awaited frame is out and the parser has settled
    task automatic write_max_payload(input logic [LIMIT_W-1:0] value);
        in_valid <= 1'b0;
        while (tracker.awaited_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.max_payload = value;
        cfg_writes++;
    endtask

    initial
    begin
        int stall_cycles;
        frame_result_t got;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                out_steady = !out_steady;
            stall_cycles = out_steady ? 0 : $urandom_range(0, 16);
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got.cls = frame_class;
            got.id = frame_id;
            got.len = payload_length;
            got.status = status_t'(frame_status);
            got.pos_valid = position_valid;
            got.pos[0] = time_of_week;
            got.pos[1] = longitude;
            got.pos[2] = latitude;
            got.pos[3] = height_ellipsoid;
            got.pos[4] = height_sea_level;
            got.pos[5] = horiz_accuracy;
            got.pos[6] = vert_accuracy;
            tracker.check_frame(got);
        end
    end

    initial
    begin
        logic [31:0]        extremes [POS_WORDS];
        logic [LIMIT_W-1:0] setting;
        int                 step;
        int                 phase_start;
        int                 random_start;
        int                 frames_start;
        int                 lim;
        extremes = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                     32'h0123_4567, 32'hFEDC_BA98, 32'h0000_0001};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset limit of 512
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        send_byte(SYNC_FIRST);
        send_frame(8'hFF, 8'h00, 16'd0, CK_CLEAN);
        for (int i = 0; i < POS_BYTES; i++)
            payload_buf[i] = extremes[i / 4][(i % 4) * 8 +: 8];
        send_frame(CLASS_NAV, ID_POSLLH, 16'(POS_BYTES), CK_CLEAN);
        send_frame(CLASS_NAV, ID_POSLLH, 16'(POS_BYTES), CK_BAD_B);
        send_frame(CLASS_NAV, ID_POSLLH, 16'd10, CK_CLEAN);
        send_frame(8'h05, 8'h01, 16'd2, CK_BAD_A);
        send_frame(8'h0A, 8'h55, 16'hFFFF, CK_CLEAN);
        send_frame(8'h01, 8'h03, 16'd513, CK_CLEAN);

        // random frames over a series of limit settings
        random_start = bytes_sent;
        frames_start = tracker.frames_checked;
        step = 0;
        while (bytes_sent - random_start < RANDOM_BYTES
               || tracker.frames_checked - frames_start < RANDOM_FRAMES)
        begin
            case (step)
                0: setting = 11'd28;
                1: setting = 11'd1024;
                2: setting = 11'd2047;
                3: setting = 11'd0;
                default: setting = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                                               : 11'($urandom_range(28, 1024));
            endcase
            write_max_payload(setting);
            lim = tracker.payload_limit();
            if (step == 0)
            begin
                fill_payload(lim);
                send_frame(CLASS_NAV, ID_POSLLH, 16'(lim), CK_CLEAN);
            end
            if (step < 2)
                send_frame(8'($urandom), 8'($urandom), 16'(lim + 1), CK_CLEAN);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_frame();
            step++;
        end

        in_valid <= 1'b0;
        while (tracker.awaited_frames.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("%0d bytes sent under %0d limit settings, %0d frames checked",
                 bytes_sent, cfg_writes, tracker.frames_checked);
        $display("%0d position fixes, %0d checksum mismatches, %0d over-length headers",
                 tracker.fixes, tracker.bad_sums, tracker.too_long);
        if (tracker.errors == 0 && tracker.awaited_frames.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
